// ===== rtl/cnsc_pkg.sv =====
// shared types and constants for the c nesting scanner core
// lexical modes, error codes and the character codes the scanner reacts to
package cnsc_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_STRING = 3'd1,
    MODE_CHAR   = 3'd2,
    MODE_SLASH  = 3'd3,
    MODE_BLOCK  = 3'd4,
    MODE_LINE   = 3'd5
  } lex_mode_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_CLOSE    = 2'd1,
    ERR_NEWLINE  = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_code_t;

  localparam int unsigned MAX_DEPTH_DEF = 255;
  localparam int unsigned DEPTH_W       = 8;
  localparam int unsigned DEPTH_CAP     = 255;

  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;

endpackage

// ===== rtl/c_code_nesting_scanner_core.sv =====
// a beat is taken into the input register, then its result is written to the result register that drives out_
// throughput: one beat per cycle while out_ready is high; the mode/depth update is a combinational loop on state
// while a result waits, one more beat is taken into the input register, then in_ready drops
// reset (rst_n low, synchronous): mode normal, depth 0, flags and initial nesting cleared
// a restart beat reloads the state from the initial nesting register, clamped to the limit
// depends on cnsc_pkg
module c_code_nesting_scanner_core #(
  parameter int unsigned MAX_DEPTH = cnsc_pkg::MAX_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_initial_nesting,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [7:0] in_source_byte,
  input  logic       in_chunk_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_lex_mode,
  output logic [7:0] out_depth,
  output logic       out_at_top_level,
  output logic [1:0] out_error_code,
  output logic       out_chunk_done
);

  localparam int unsigned LIMIT_I =
    (MAX_DEPTH > cnsc_pkg::DEPTH_CAP) ? cnsc_pkg::DEPTH_CAP : MAX_DEPTH;
  localparam logic [cnsc_pkg::DEPTH_W-1:0] LIMIT = LIMIT_I[cnsc_pkg::DEPTH_W-1:0];

  logic [7:0] init_r;

  logic       s1_valid_r;
  logic       s1_func_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_adv;

  cnsc_pkg::lex_mode_t           mode_r, mode_nxt;
  logic [cnsc_pkg::DEPTH_W-1:0]  depth_r, depth_nxt;
  logic                          esc_r, esc_nxt;
  logic                          star_r, star_nxt;
  cnsc_pkg::err_code_t           err_nxt;
  logic [cnsc_pkg::DEPTH_W-1:0]  init_clamped;
  logic                          do_normal;

  logic       out_valid_r;
  logic [2:0] out_mode_r;
  logic [7:0] out_depth_r;
  logic       out_top_r;
  logic [1:0] out_err_r;
  logic       out_last_r;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;

  assign init_clamped = (init_r > LIMIT) ? LIMIT : init_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0;
    end else if (cfg_valid) begin
      init_r <= cfg_initial_nesting;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func_r <= in_func;
      s1_byte_r <= in_source_byte;
      s1_last_r <= in_chunk_last;
    end
  end

  // scanner state update
  always_comb begin
    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    esc_nxt   = esc_r;
    star_nxt  = star_r;
    err_nxt   = cnsc_pkg::ERR_NONE;
    do_normal = 1'b0;
    if (s1_func_r) begin
      mode_nxt  = cnsc_pkg::MODE_NORMAL;
      depth_nxt = init_clamped;
      esc_nxt   = 1'b0;
      star_nxt  = 1'b0;
    end else begin
      unique case (mode_r)
        cnsc_pkg::MODE_STRING, cnsc_pkg::MODE_CHAR: begin
          priority if (esc_r) begin
            esc_nxt = 1'b0;
          end else if ((mode_r == cnsc_pkg::MODE_STRING && s1_byte_r == cnsc_pkg::CH_DQUOTE) ||
                       (mode_r == cnsc_pkg::MODE_CHAR && s1_byte_r == cnsc_pkg::CH_SQUOTE)) begin
            mode_nxt = cnsc_pkg::MODE_NORMAL;
          end else if (s1_byte_r == cnsc_pkg::CH_BACKSLASH) begin
            esc_nxt = 1'b1;
          end else if (s1_byte_r == cnsc_pkg::CH_NEWLINE) begin
            err_nxt = cnsc_pkg::ERR_NEWLINE;
          end else begin
            esc_nxt = 1'b0;
          end
        end
        cnsc_pkg::MODE_SLASH: begin
          priority if (s1_byte_r == cnsc_pkg::CH_STAR) begin
            mode_nxt = cnsc_pkg::MODE_BLOCK;
            star_nxt = 1'b0;
          end else if (s1_byte_r == cnsc_pkg::CH_SLASH) begin
            mode_nxt = cnsc_pkg::MODE_LINE;
          end else begin
            do_normal = 1'b1;
          end
        end
        cnsc_pkg::MODE_BLOCK: begin
          if (star_r && s1_byte_r == cnsc_pkg::CH_SLASH) begin
            mode_nxt = cnsc_pkg::MODE_NORMAL;
            star_nxt = 1'b0;
          end else begin
            star_nxt = (s1_byte_r == cnsc_pkg::CH_STAR);
          end
        end
        cnsc_pkg::MODE_LINE: begin
          if (s1_byte_r == cnsc_pkg::CH_NEWLINE) begin
            mode_nxt = cnsc_pkg::MODE_NORMAL;
          end
        end
        default: begin
          do_normal = 1'b1;
        end
      endcase
      if (do_normal) begin
        mode_nxt = cnsc_pkg::MODE_NORMAL;
        unique case (s1_byte_r)
          cnsc_pkg::CH_LBRACE, cnsc_pkg::CH_LPAREN, cnsc_pkg::CH_LBRACKET: begin
            if (depth_r >= LIMIT) begin
              err_nxt = cnsc_pkg::ERR_OVERFLOW;
            end else begin
              depth_nxt = depth_r + 1'b1;
            end
          end
          cnsc_pkg::CH_RBRACE, cnsc_pkg::CH_RPAREN, cnsc_pkg::CH_RBRACKET: begin
            if (depth_r == '0) begin
              err_nxt = cnsc_pkg::ERR_CLOSE;
            end else begin
              depth_nxt = depth_r - 1'b1;
            end
          end
          cnsc_pkg::CH_DQUOTE: mode_nxt = cnsc_pkg::MODE_STRING;
          cnsc_pkg::CH_SQUOTE: mode_nxt = cnsc_pkg::MODE_CHAR;
          cnsc_pkg::CH_SLASH:  mode_nxt = cnsc_pkg::MODE_SLASH;
          default: begin
            mode_nxt = cnsc_pkg::MODE_NORMAL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= cnsc_pkg::MODE_NORMAL;
      depth_r <= '0;
      esc_r   <= 1'b0;
      star_r  <= 1'b0;
    end else if (s1_adv) begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      esc_r   <= esc_nxt;
      star_r  <= star_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_mode_r  <= mode_nxt;
      out_depth_r <= depth_nxt;
      out_top_r   <= (mode_nxt == cnsc_pkg::MODE_NORMAL || mode_nxt == cnsc_pkg::MODE_SLASH) &&
                     (depth_nxt == '0);
      out_err_r   <= err_nxt;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lex_mode     = out_mode_r;
  assign out_depth        = out_depth_r;
  assign out_at_top_level = out_top_r;
  assign out_error_code   = out_err_r;
  assign out_chunk_done   = out_last_r;

endmodule
